### rtl/bfha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned BYTE_W = 16;
  localparam int unsigned NEED_W = 17;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [11:0] request_size;
    logic [11:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_address;
  } rsp_t;

  typedef struct packed {
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] pay;
    logic              used;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_ROTATE,
    CMD_ALLOC,
    CMD_SETFREE,
    CMD_DROP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    entry_t           ent_a;
    entry_t           ent_b;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_DROP,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

### rtl/bfha_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bfha_cell
  import bfha_pkg::*;
#(
  parameter int unsigned INDEX        = 0,
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   cmd,
  input  wire entry_t left,
  input  wire entry_t right,
  output entry_t      ent
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [CNT_W-1:0] idx_x;
  logic [CNT_W-1:0] idx_p1;

  assign idx_x  = {1'b0, cmd.idx};
  assign idx_p1 = idx_x + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.used <= 1'b0;
      if (INDEX == 0) begin
        ent.off <= '0;
        ent.pay <= BYTE_W'(ARENA_BYTES - HEADER_BYTES);
      end
    end else begin
      case (cmd.op)
        CMD_ROTATE: ent <= right;
        CMD_ALLOC: begin
          if (idx_x == MY_IDX) begin
            ent <= cmd.ent_a;
          end else if (idx_p1 == MY_IDX) begin
            ent <= cmd.ent_b;
          end else if (MY_IDX > idx_p1 && MY_IDX <= cmd.cnt) begin
            ent <= left;
          end
        end
        CMD_SETFREE: begin
          if (idx_x == MY_IDX) begin
            ent <= cmd.ent_a;
          end
        end
        CMD_DROP: begin
          if (MY_IDX >= idx_x) begin
            ent <= right;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/best_fit_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_ready | req_t: operation, request_size, free_address
// rsp     | out | rsp_valid / rsp_ready | rsp_t: status, payload_address
//
// A word's result is registered after acceptance in these steps: the ring of
// cells rotates once past the head cell for the search, an update step, up to
// two entry drops on a merging free, and the move into the output register.
// The next word is accepted only once the block is back in the idle state.
// Synchronous reset leaves one free block covering the arena.
// A finished word waits in the output register; a stalled rsp holds the next.
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam logic [BYTE_W-1:0] HDR = BYTE_W'(HEADER_BYTES);
  localparam logic [IDX_W-1:0]  LAST = IDX_W'(MAX_BLOCKS - 1);

  state_t state, state_next;
  cmd_t   cmd;
  entry_t cells [MAX_BLOCKS];
  entry_t head;

  req_t             cur;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] count;

  logic              found;
  logic [IDX_W-1:0]  best;
  logic [BYTE_W-1:0] best_off, best_pay;

  logic              prev_use;
  logic [BYTE_W-1:0] prev_off, prev_pay;
  logic              hit_found, grab_next;
  logic [IDX_W-1:0]  hit;
  logic [BYTE_W-1:0] hit_off, hit_pay, hp_off, hp_pay, hn_pay;
  logic              hp_free, hn_free;

  logic [1:0]        drops;
  logic [IDX_W-1:0]  drop_at;
  logic [1:0]        res_status;
  logic [11:0]       res_addr;

  logic              in_range, fits, better, match;
  logic [NEED_W-1:0] need;
  logic [BYTE_W-1:0] rem, new_off;
  logic              alloc_ok;
  logic [IDX_W-1:0]  tgt_idx, plan_drop_at;
  entry_t            tgt_ent;
  logic [1:0]        plan_drops;
  logic              last_k;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
      bfha_cell #(
        .INDEX       (gi),
        .ARENA_BYTES (ARENA_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .cmd  (cmd),
        .left (cells[(gi + MAX_BLOCKS - 1) % MAX_BLOCKS]),
        .right(cells[(gi + 1) % MAX_BLOCKS]),
        .ent  (cells[gi])
      );
    end
  endgenerate

  assign head   = cells[0];
  assign last_k = (k == LAST);

  always_comb begin
    in_range = ({1'b0, k} < count);
    need     = NEED_W'(cur.request_size) + NEED_W'(HEADER_BYTES);
    fits     = in_range && !head.used && (NEED_W'(head.pay) >= need);
    better   = !found || (head.pay <= best_pay);
    match    = in_range && head.used && (cur.free_address != 12'd0) &&
               (NEED_W'(head.off) + NEED_W'(HEADER_BYTES) == NEED_W'(cur.free_address));
    alloc_ok = found && (count < CNT_W'(MAX_BLOCKS));
    rem      = best_pay - BYTE_W'(need);
    new_off  = best_off + HDR + rem;

    tgt_idx      = hit;
    tgt_ent      = '{off: hit_off, pay: hit_pay, used: 1'b0};
    plan_drops   = 2'd0;
    plan_drop_at = hit;
    if (hp_free && hn_free) begin
      tgt_idx    = hit - IDX_W'(1);
      tgt_ent    = '{off: hp_off, pay: hp_pay + hit_pay + hn_pay + HDR + HDR, used: 1'b0};
      plan_drops = 2'd2;
    end else if (hp_free) begin
      tgt_idx    = hit - IDX_W'(1);
      tgt_ent    = '{off: hp_off, pay: hp_pay + hit_pay + HDR, used: 1'b0};
      plan_drops = 2'd1;
    end else if (hn_free) begin
      tgt_ent      = '{off: hit_off, pay: hit_pay + hn_pay + HDR, used: 1'b0};
      plan_drops   = 2'd1;
      plan_drop_at = hit + IDX_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_valid) state_next = S_SCAN;
      S_SCAN:   if (last_k) state_next = S_APPLY;
      S_APPLY: begin
        if (cur.operation == OP_FREE && hit_found && plan_drops != 2'd0) begin
          state_next = S_DROP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DROP:   if (drops == 2'd1) state_next = S_FINISH;
      S_FINISH: if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '{op: CMD_IDLE, idx: '0, cnt: count, ent_a: '0, ent_b: '0};
    unique case (state)
      S_IDLE: req_ready = 1'b1;
      S_SCAN: cmd.op = CMD_ROTATE;
      S_APPLY: begin
        if (cur.operation == OP_ALLOC) begin
          if (alloc_ok) begin
            cmd.op    = CMD_ALLOC;
            cmd.idx   = best;
            cmd.ent_a = '{off: best_off, pay: rem, used: 1'b0};
            cmd.ent_b = '{off: new_off, pay: BYTE_W'(cur.request_size), used: 1'b1};
          end
        end else if (hit_found) begin
          cmd.op    = CMD_SETFREE;
          cmd.idx   = tgt_idx;
          cmd.ent_a = tgt_ent;
        end
      end
      S_DROP: begin
        cmd.op  = CMD_DROP;
        cmd.idx = drop_at;
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= CNT_W'(1);
      rsp_valid <= 1'b0;
      k         <= '0;
      drops     <= 2'd0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready && state != S_FINISH) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur       <= req;
            k         <= '0;
            found     <= 1'b0;
            best_pay  <= '0;
            hit_found <= 1'b0;
            grab_next <= 1'b0;
            hp_free   <= 1'b0;
            hn_free   <= 1'b0;
            prev_use  <= 1'b1;
          end
        end
        S_SCAN: begin
          k         <= last_k ? '0 : k + IDX_W'(1);
          prev_use  <= head.used;
          prev_off  <= head.off;
          prev_pay  <= head.pay;
          grab_next <= !hit_found && match;
          if (fits && better) begin
            found    <= 1'b1;
            best     <= k;
            best_off <= head.off;
            best_pay <= head.pay;
          end
          if (grab_next && in_range) begin
            hn_free <= !head.used;
            hn_pay  <= head.pay;
          end
          if (!hit_found && match) begin
            hit_found <= 1'b1;
            hit       <= k;
            hit_off   <= head.off;
            hit_pay   <= head.pay;
            hp_free   <= (k != '0) && !prev_use;
            hp_off    <= prev_off;
            hp_pay    <= prev_pay;
          end
        end
        S_APPLY: begin
          if (cur.operation == OP_ALLOC) begin
            drops <= 2'd0;
            if (alloc_ok) begin
              res_status <= ST_ALLOC;
              res_addr   <= 12'(new_off + HDR);
              count      <= count + CNT_W'(1);
            end else begin
              res_status <= ST_NOFIT;
              res_addr   <= 12'd0;
            end
          end else if (hit_found) begin
            res_status <= ST_FREED;
            res_addr   <= 12'd0;
            drops      <= plan_drops;
            drop_at    <= plan_drop_at;
          end else begin
            res_status <= ST_IGNORED;
            res_addr   <= 12'd0;
            drops      <= 2'd0;
          end
        end
        S_DROP: begin
          drops <= drops - 2'd1;
          count <= count - CNT_W'(1);
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid           <= 1'b1;
            rsp.status          <= res_status;
            rsp.payload_address <= res_addr;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_scan_rotates: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cmd.op == CMD_ROTATE))
    else $error("scan without rotation");

  a_scan_wraps: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && last_k) |=> (state == S_APPLY && k == '0))
    else $error("ring did not return to home position");

  a_no_drop_on_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP) |-> (cur.operation == OP_FREE && drops != 2'd0))
    else $error("entry drop outside a merging free");

endmodule
`default_nettype wire
